@@ hdl/assert_macros.svh @@
// Assertion macros used by the datapath RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hdl/oale_pkg.sv @@
// Shared constants, codes and controller/datapath interface types.
package oale_pkg;

  localparam int CAPACITY    = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int MODE_W      = 3;
  localparam int POS_W       = 10;
  localparam int DATA_W      = 32;
  localparam int STAT_W      = 2;
  localparam int FILL_W      = 11;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_READ   = 3'd2,
    MODE_FIND   = 3'd3,
    MODE_SWAP   = 3'd4,
    MODE_MOVE   = 3'd5,
    MODE_CLEAR  = 3'd6
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_ABSENT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_FINAL,
    S_HOLD_CAP,
    S_SW_RB,
    S_SW_WA,
    S_SW_WB,
    S_RD_CAP,
    S_FIND,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    INIT_NONE,
    INIT_INS,
    INIT_REM,
    INIT_MOV,
    INIT_FIND
  } init_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_POS,
    RD_POS2
  } rd_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_VALUE,
    WR_HELD,
    WR_SWAP_A,
    WR_SWAP_B
  } wr_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_t;

  typedef enum logic [1:0] {
    IDX_NONE,
    IDX_INS,
    IDX_FIND
  } idx_t;

  typedef struct packed {
    logic    load_req;
    init_t   init;
    logic    shift_step;
    logic    find_step;
    rd_t     rd;
    wr_t     wr;
    logic    held_cap;
    logic    rv_cap;
    logic    set_st;
    status_t st;
    idx_t    idx;
    cnt_t    cnt;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  pos_ok;
    logic  pos2_ok;
    logic  at_stop;
    logic  scan_end;
    logic  cmp_pend;
    logic  found;
  } dp_stat_t;

endpackage

@@ hdl/oale_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module oale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/oale_ctrl.sv @@
// Controller state machine: sequences each request over the datapath.
module oale_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output oale_pkg::dp_cmd_t  cmd,
  input  oale_pkg::dp_stat_t stat
);

  oale_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == oale_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oale_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      oale_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = oale_pkg::S_DECODE;
        end
      end
      oale_pkg::S_DECODE: begin
        state_nxt = oale_pkg::S_DONE;
        unique case (stat.mode)
          oale_pkg::MODE_INSERT: begin
            if (stat.full) begin
              cmd.set_st = 1'b1;
              cmd.st     = oale_pkg::STAT_FULL;
            end else begin
              cmd.init  = oale_pkg::INIT_INS;
              cmd.idx   = oale_pkg::IDX_INS;
              state_nxt = oale_pkg::S_SHIFT;
            end
          end
          oale_pkg::MODE_REMOVE: begin
            if (!stat.pos_ok) begin
              cmd.set_st = 1'b1;
              cmd.st     = oale_pkg::STAT_RANGE;
            end else begin
              cmd.init  = oale_pkg::INIT_REM;
              state_nxt = oale_pkg::S_SHIFT;
            end
          end
          oale_pkg::MODE_READ: begin
            if (!stat.pos_ok) begin
              cmd.set_st = 1'b1;
              cmd.st     = oale_pkg::STAT_RANGE;
            end else begin
              cmd.rd    = oale_pkg::RD_POS;
              state_nxt = oale_pkg::S_RD_CAP;
            end
          end
          oale_pkg::MODE_FIND: begin
            cmd.init  = oale_pkg::INIT_FIND;
            state_nxt = oale_pkg::S_FIND;
          end
          oale_pkg::MODE_SWAP: begin
            if (!(stat.pos_ok && stat.pos2_ok)) begin
              cmd.set_st = 1'b1;
              cmd.st     = oale_pkg::STAT_RANGE;
            end else begin
              cmd.rd    = oale_pkg::RD_POS;
              state_nxt = oale_pkg::S_SW_RB;
            end
          end
          oale_pkg::MODE_MOVE: begin
            if (!(stat.pos_ok && stat.pos2_ok)) begin
              cmd.set_st = 1'b1;
              cmd.st     = oale_pkg::STAT_RANGE;
            end else begin
              cmd.rd    = oale_pkg::RD_POS;
              state_nxt = oale_pkg::S_HOLD_CAP;
            end
          end
          oale_pkg::MODE_CLEAR: begin
            cmd.cnt = oale_pkg::CNT_CLR;
          end
          default: begin
          end
        endcase
      end
      oale_pkg::S_HOLD_CAP: begin
        cmd.held_cap = 1'b1;
        cmd.init     = oale_pkg::INIT_MOV;
        state_nxt    = oale_pkg::S_SHIFT;
      end
      oale_pkg::S_SHIFT: begin
        // the last pending write drains in the cycle that sees the stop
        if (stat.at_stop) begin
          state_nxt = oale_pkg::S_FINAL;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      oale_pkg::S_FINAL: begin
        state_nxt = oale_pkg::S_DONE;
        unique case (stat.mode)
          oale_pkg::MODE_INSERT: begin
            cmd.wr  = oale_pkg::WR_VALUE;
            cmd.cnt = oale_pkg::CNT_INC;
          end
          oale_pkg::MODE_MOVE: begin
            cmd.wr = oale_pkg::WR_HELD;
          end
          oale_pkg::MODE_REMOVE: begin
            cmd.cnt = oale_pkg::CNT_DEC;
          end
          default: begin
          end
        endcase
      end
      oale_pkg::S_SW_RB: begin
        cmd.held_cap = 1'b1;
        cmd.rd       = oale_pkg::RD_POS2;
        state_nxt    = oale_pkg::S_SW_WA;
      end
      oale_pkg::S_SW_WA: begin
        cmd.wr    = oale_pkg::WR_SWAP_A;
        state_nxt = oale_pkg::S_SW_WB;
      end
      oale_pkg::S_SW_WB: begin
        cmd.wr    = oale_pkg::WR_SWAP_B;
        state_nxt = oale_pkg::S_DONE;
      end
      oale_pkg::S_RD_CAP: begin
        cmd.rv_cap = 1'b1;
        state_nxt  = oale_pkg::S_DONE;
      end
      oale_pkg::S_FIND: begin
        if (stat.found) begin
          cmd.idx   = oale_pkg::IDX_FIND;
          state_nxt = oale_pkg::S_DONE;
        end else if (stat.scan_end && !stat.cmp_pend) begin
          cmd.set_st = 1'b1;
          cmd.st     = oale_pkg::STAT_ABSENT;
          state_nxt  = oale_pkg::S_DONE;
        end else if (!stat.scan_end) begin
          cmd.find_step = 1'b1;
        end
      end
      oale_pkg::S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = oale_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = oale_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/oale_dpath.sv @@
// Datapath: request latch, fill count, walk cursor, entry RAM and result registers.
`include "assert_macros.svh"

module oale_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [oale_pkg::MODE_W-1:0]       in_mode,
  input  logic [oale_pkg::POS_W-1:0]        in_position,
  input  logic [oale_pkg::POS_W-1:0]        in_second_position,
  input  logic [oale_pkg::DATA_W-1:0]       in_value,
  output logic [oale_pkg::STAT_W-1:0]       out_status,
  output logic [oale_pkg::DATA_W-1:0]       out_read_value,
  output logic [oale_pkg::POS_W-1:0]        out_result_index,
  output logic [oale_pkg::FILL_W-1:0]       out_fill_count,
  input  oale_pkg::dp_cmd_t                 cmd,
  output oale_pkg::dp_stat_t                stat
);

  localparam int IW = oale_pkg::IDX_W;
  localparam int CW = oale_pkg::CNT_W;
  localparam int VW = oale_pkg::VALUE_WIDTH;

  oale_pkg::mode_t             mode_r;
  logic [oale_pkg::POS_W-1:0]  pos_r, pos2_r;
  logic [VW-1:0]               val_r, held_r, res_rv_r;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               cur_r, stop_r, cur_step, ins_pos;
  logic                        up_r, pw_r, cmp_v_r;
  logic [IW-1:0]               wa_r, cmp_a_r, res_idx_r;
  oale_pkg::status_t           res_st_r;
  logic [31:0]                 pos_w, pos2_w, cnt_w;
  logic                        full;

  logic                        ram_we, ram_re;
  logic [IW-1:0]               ram_waddr, ram_raddr;
  logic [VW-1:0]               ram_wdata, ram_rdata;

  oale_ram #(
    .WIDTH(VW),
    .DEPTH(oale_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign pos_w    = 32'(pos_r);
  assign pos2_w   = 32'(pos2_r);
  assign cnt_w    = 32'(count_r);
  assign full     = (count_r == CW'(oale_pkg::CAPACITY));
  assign ins_pos  = (pos_w > cnt_w) ? count_r : CW'(pos_w);
  assign cur_step = up_r ? (cur_r - CW'(1)) : (cur_r + CW'(1));

  assign stat.mode     = mode_r;
  assign stat.full     = full;
  assign stat.pos_ok   = (pos_w < cnt_w);
  assign stat.pos2_ok  = (pos2_w < cnt_w);
  assign stat.at_stop  = (cur_r == stop_r);
  assign stat.scan_end = (cur_r == count_r);
  assign stat.cmp_pend = cmp_v_r;
  assign stat.found    = cmp_v_r && (ram_rdata == val_r);

  // read port
  always_comb begin
    ram_re    = 1'b1;
    ram_raddr = IW'(pos_r);
    if (cmd.shift_step) begin
      ram_raddr = cur_step[IW-1:0];
    end else if (cmd.find_step) begin
      ram_raddr = cur_r[IW-1:0];
    end else begin
      case (cmd.rd)
        oale_pkg::RD_POS:  ram_raddr = IW'(pos_r);
        oale_pkg::RD_POS2: ram_raddr = IW'(pos2_r);
        default:           ram_re    = 1'b0;
      endcase
    end
  end

  // write port: a pending shift write wins
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wa_r;
    ram_wdata = ram_rdata;
    if (pw_r) begin
      ram_we = 1'b1;
    end else begin
      case (cmd.wr)
        oale_pkg::WR_VALUE: begin
          ram_we    = 1'b1;
          ram_waddr = stop_r[IW-1:0];
          ram_wdata = val_r;
        end
        oale_pkg::WR_HELD: begin
          ram_we    = 1'b1;
          ram_waddr = stop_r[IW-1:0];
          ram_wdata = held_r;
        end
        oale_pkg::WR_SWAP_A: begin
          ram_we    = 1'b1;
          ram_waddr = IW'(pos_r);
        end
        oale_pkg::WR_SWAP_B: begin
          ram_we    = 1'b1;
          ram_waddr = IW'(pos2_r);
          ram_wdata = held_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cmd.cnt)
      oale_pkg::CNT_INC: count_nxt = count_r + CW'(1);
      oale_pkg::CNT_DEC: count_nxt = count_r - CW'(1);
      oale_pkg::CNT_CLR: count_nxt = '0;
      default:           count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pw_r    <= 1'b0;
      cmp_v_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pw_r    <= cmd.shift_step;
      cmp_v_r <= cmd.find_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      mode_r    <= oale_pkg::mode_t'(in_mode);
      pos_r     <= in_position;
      pos2_r    <= in_second_position;
      val_r     <= VW'(in_value);
      res_st_r  <= oale_pkg::STAT_OK;
      res_rv_r  <= '0;
      res_idx_r <= '0;
    end
    case (cmd.init)
      oale_pkg::INIT_INS: begin
        cur_r  <= count_r;
        stop_r <= ins_pos;
        up_r   <= 1'b1;
      end
      oale_pkg::INIT_REM: begin
        cur_r  <= CW'(pos_w);
        stop_r <= count_r - CW'(1);
        up_r   <= 1'b0;
      end
      oale_pkg::INIT_MOV: begin
        cur_r  <= CW'(pos_w);
        stop_r <= CW'(pos2_w);
        up_r   <= (pos2_w < pos_w);
      end
      oale_pkg::INIT_FIND: begin
        cur_r <= '0;
      end
      default: begin
        if (cmd.shift_step) begin
          cur_r <= cur_step;
          wa_r  <= cur_r[IW-1:0];
        end else if (cmd.find_step) begin
          cur_r   <= cur_r + CW'(1);
          cmp_a_r <= cur_r[IW-1:0];
        end
      end
    endcase
    if (cmd.held_cap) begin
      held_r <= ram_rdata;
    end
    if (cmd.rv_cap) begin
      res_rv_r <= ram_rdata;
    end
    if (cmd.set_st) begin
      res_st_r <= cmd.st;
    end
    case (cmd.idx)
      oale_pkg::IDX_INS:  res_idx_r <= ins_pos[IW-1:0];
      oale_pkg::IDX_FIND: res_idx_r <= cmp_a_r;
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      out_status       <= res_st_r;
      out_read_value   <= oale_pkg::DATA_W'(res_rv_r);
      out_result_index <= oale_pkg::POS_W'(res_idx_r);
      out_fill_count   <= oale_pkg::FILL_W'(count_r);
    end
  end

  `ASSERT_ALWAYS(a_count_cap, count_r <= CW'(oale_pkg::CAPACITY), "fill count above capacity")
  `ASSERT_ALWAYS(a_wr_clash, !(pw_r && (cmd.wr != oale_pkg::WR_NONE)), "write port clash")
  `ASSERT_IMPL(a_step_stop, cmd.shift_step, cur_r != stop_r, "shift stepped past its stop")
  `ASSERT_IMPL(a_ins_room, cmd.cnt == oale_pkg::CNT_INC, !full, "insert into a full array")

endmodule

@@ hdl/ordered_array_list_engine.sv @@
// Ordered array list engine: top level joining controller and datapath.
// Each item is decoded; insert, remove and move then walk the entries one per cycle, find scans
// from index 0 until a hit or the fill count, and read, swap and clear need no walk.
// Rejected items (full, out of range) and the unused mode go straight to the result.
// Items are handled one at a time: no new item is taken until the last result is loaded into
// the output register. A new item is taken while a result waits in the output register.
// Reset (rst_n low, synchronous) empties the array and drops any held result.
module ordered_array_list_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [oale_pkg::MODE_W-1:0]   in_mode,
  input  logic [oale_pkg::POS_W-1:0]    in_position,
  input  logic [oale_pkg::POS_W-1:0]    in_second_position,
  input  logic [oale_pkg::DATA_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [oale_pkg::STAT_W-1:0]   out_status,
  output logic [oale_pkg::DATA_W-1:0]   out_read_value,
  output logic [oale_pkg::POS_W-1:0]    out_result_index,
  output logic [oale_pkg::FILL_W-1:0]   out_fill_count
);

  // commands flow controller -> datapath, status flows back
  oale_pkg::dp_cmd_t  cmd;
  oale_pkg::dp_stat_t stat;

  // sequence each request: decode, then walk, scan, read or swap, any final write, result hand-off
  oale_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // hold the request, the fill count, the entry RAM and the result item
  oale_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mode           (in_mode),
    .in_position       (in_position),
    .in_second_position(in_second_position),
    .in_value          (in_value),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_result_index  (out_result_index),
    .out_fill_count    (out_fill_count),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule
